/* rtl/core/mfde_pkg.sv */
// Shared types, constants and font tables for the framebuffer draw engine.
// No dependencies.
package mfde_pkg;

    localparam int ROWS      = 16;
    localparam int ROW_BYTES = 32;
    localparam int ROW_W     = $clog2(ROWS);
    localparam int COL_W     = $clog2(ROW_BYTES);
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int DEPTH     = ROWS * ROW_BYTES;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    typedef enum logic [2:0] {
        CMD_PUT   = 3'd0,
        CMD_RDPX  = 3'd1,
        CMD_FILL  = 3'd2,
        CMD_HLINE = 3'd3,
        CMD_VLINE = 3'd4,
        CMD_FRAME = 3'd5,
        CMD_CHAR  = 3'd6,
        CMD_RDBY  = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MOD,
        ST_NEXT,
        ST_OUT
    } state_t;

    // Glyph width by code (space for anything unprintable)
    function automatic logic [2:0] glyph_width(input logic [7:0] code);
        logic [2:0] w;
        begin
            if (code == 8'd33) w = 3'd2;
            else if (code == 8'd34) w = 3'd4;
            else if (code > 8'd34 && code < 8'd127) w = 3'd6;
            else w = 3'd2;
            return w;
        end
    endfunction

    // Glyph column bits, bit 0 top
    function automatic logic [7:0] glyph_col(input logic [7:0] code, input logic [2:0] c);
        logic [47:0] g;
        begin
            case (code)
                8'd33:  g = 48'h00_00_00_00_00_5F;
                8'd34:  g = 48'h00_00_00_03_00_03;
                8'd35:  g = 48'h00_14_7F_14_7F_14;
                8'd36:  g = 48'h00_12_2A_7F_2A_24;
                8'd37:  g = 48'h00_62_64_08_13_23;
                8'd38:  g = 48'h00_50_22_55_49_36;
                8'd39:  g = 48'h00_00_00_03_00_00;
                8'd40:  g = 48'h00_00_41_22_1C_00;
                8'd41:  g = 48'h00_00_1C_22_41_00;
                8'd42:  g = 48'h00_14_08_3E_08_14;
                8'd43:  g = 48'h00_08_08_3E_08_08;
                8'd44:  g = 48'h00_00_30_50_00_00;
                8'd45:  g = 48'h00_08_08_08_08_08;
                8'd46:  g = 48'h00_00_60_60_00_00;
                8'd47:  g = 48'h00_02_04_08_10_20;
                8'd48:  g = 48'h00_3E_45_49_51_3E;
                8'd49:  g = 48'h00_00_40_7F_42_00;
                8'd50:  g = 48'h00_46_49_51_61_42;
                8'd51:  g = 48'h00_31_4B_45_41_21;
                8'd52:  g = 48'h00_10_7F_12_14_18;
                8'd53:  g = 48'h00_39_45_45_45_27;
                8'd54:  g = 48'h00_30_49_49_4A_3C;
                8'd55:  g = 48'h00_07_09_71_01_03;
                8'd56:  g = 48'h00_36_49_49_49_36;
                8'd57:  g = 48'h00_1E_29_49_49_06;
                8'd58:  g = 48'h00_00_36_36_00_00;
                8'd59:  g = 48'h00_00_36_56_00_00;
                8'd60:  g = 48'h00_00_41_22_14_08;
                8'd61:  g = 48'h00_14_14_14_14_14;
                8'd62:  g = 48'h00_00_08_14_22_41;
                8'd63:  g = 48'h00_06_09_51_01_02;
                8'd64:  g = 48'h00_3E_41_79_49_32;
                8'd65:  g = 48'h00_7E_11_11_11_7E;
                8'd66:  g = 48'h00_36_49_49_49_7F;
                8'd67:  g = 48'h00_22_41_41_41_3E;
                8'd68:  g = 48'h00_1C_22_41_41_7F;
                8'd69:  g = 48'h00_41_49_49_49_7F;
                8'd70:  g = 48'h00_01_09_09_09_7F;
                8'd71:  g = 48'h00_7A_49_49_41_3E;
                8'd72:  g = 48'h00_7F_08_08_08_7F;
                8'd73:  g = 48'h00_00_41_7F_41_00;
                8'd74:  g = 48'h00_01_3F_41_40_20;
                8'd75:  g = 48'h00_41_22_14_08_7F;
                8'd76:  g = 48'h00_40_40_40_40_7F;
                8'd77:  g = 48'h00_7F_02_0C_02_7F;
                8'd78:  g = 48'h00_7F_10_08_04_7F;
                8'd79:  g = 48'h00_3E_41_41_41_3E;
                8'd80:  g = 48'h00_06_09_09_09_7F;
                8'd81:  g = 48'h00_5E_21_51_41_3E;
                8'd82:  g = 48'h00_46_29_19_09_7F;
                8'd83:  g = 48'h00_31_49_49_49_46;
                8'd84:  g = 48'h00_01_01_7F_01_01;
                8'd85:  g = 48'h00_3F_40_40_40_3F;
                8'd86:  g = 48'h00_1F_20_40_20_1F;
                8'd87:  g = 48'h00_3F_40_38_40_3F;
                8'd88:  g = 48'h00_63_14_08_14_63;
                8'd89:  g = 48'h00_07_08_70_08_07;
                8'd90:  g = 48'h00_43_45_49_51_61;
                8'd91:  g = 48'h00_00_41_41_7F_00;
                8'd92:  g = 48'h00_20_10_08_04_02;
                8'd93:  g = 48'h00_00_7F_41_41_00;
                8'd94:  g = 48'h00_04_02_01_02_04;
                8'd95:  g = 48'h00_40_40_40_40_40;
                8'd96:  g = 48'h00_00_04_02_01_00;
                8'd97:  g = 48'h00_78_54_54_54_20;
                8'd98:  g = 48'h00_38_44_44_48_7F;
                8'd99:  g = 48'h00_20_44_44_44_38;
                8'd100: g = 48'h00_7F_48_44_44_38;
                8'd101: g = 48'h00_18_54_54_54_38;
                8'd102: g = 48'h00_02_01_09_7E_08;
                8'd103: g = 48'h00_3C_52_52_52_0C;
                8'd104: g = 48'h00_78_04_04_08_7F;
                8'd105: g = 48'h00_00_40_7D_44_00;
                8'd106: g = 48'h00_00_3D_44_40_20;
                8'd107: g = 48'h00_00_44_28_10_7F;
                8'd108: g = 48'h00_00_40_7F_41_00;
                8'd109: g = 48'h00_70_08_30_08_78;
                8'd110: g = 48'h00_70_08_08_10_78;
                8'd111: g = 48'h00_30_48_48_48_30;
                8'd112: g = 48'h00_08_14_14_14_7C;
                8'd113: g = 48'h00_7C_18_14_14_08;
                8'd114: g = 48'h00_08_04_04_08_7C;
                8'd115: g = 48'h00_20_54_54_54_48;
                8'd116: g = 48'h00_20_40_44_3F_04;
                8'd117: g = 48'h00_7C_20_40_40_3C;
                8'd118: g = 48'h00_1C_20_40_20_1C;
                8'd119: g = 48'h00_3C_40_38_40_3C;
                8'd120: g = 48'h00_44_28_10_28_44;
                8'd121: g = 48'h00_3C_50_50_50_0C;
                8'd122: g = 48'h00_44_4C_54_64_44;
                8'd123: g = 48'h00_00_41_36_08_00;
                8'd124: g = 48'h00_00_00_7F_00_00;
                8'd125: g = 48'h00_00_08_36_41_00;
                8'd126: g = 48'h00_08_10_08_04_08;
                default: g = 48'h0;
            endcase
            return g[c*8 +: 8];
        end
    endfunction

endpackage

/* rtl/core/mono_framebuffer_draw_engine.sv */
// Framebuffer draw engine: command sequencer around a 512 x 8 frame store.
// Depends on mfde_pkg.
//
//  channel | dir | tdata fields (low bit up)                          | tuser
//  s_axis  | in  | command, x_a, y_a, x_b, y_b, color, char_code       | -
//  m_axis  | out | pixel_value, byte_value, glyph_width               | -
//
// Each command walks its pixels one at a time: read byte, then merge and write
// (a glyph is walked column by column, 8 rows each). Accept and address setup
// come first and the result last; a read or an empty range still walks one pixel.
// After reset a clearing pass zeroes all 512 bytes of the store; no command is taken.
// A pending result holds until m_axis_tready; the next command waits for it.
module mono_framebuffer_draw_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // command, x_a, y_a, x_b, y_b, color, char_code
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // pixel_value, byte_value, glyph_width
);

    mfde_pkg::state_t state_reg, state_next;
    logic [2:0] cmd_reg;
    logic [7:0] xa_reg, ya_reg, xb_reg, yb_reg, code_reg;
    logic       color_reg;
    // Walk position and phase (phase: frame pass or glyph column)
    logic [7:0] x_reg, x_next, y_reg, y_next;
    logic [1:0] ph_reg, ph_next;
    logic [2:0] gc_reg, gc_next;
    logic [mfde_pkg::ADDR_W-1:0] clr_reg;
    logic [7:0] mem [mfde_pkg::DEPTH];
    logic [7:0] rd_reg;
    logic       pix_reg;
    logic [7:0] byte_reg;
    logic [2:0] gw_reg;

    // Current pixel target
    logic [7:0] px, py;
    logic       pact, pon;
    logic [7:0] gcol;
    logic       we;
    logic [mfde_pkg::ADDR_W-1:0] waddr, paddr;
    logic [7:0] wdata, bitm;
    logic       last;
    logic       yin;

    // Empty range flag and incoming command fields
    logic empty_reg;
    logic [2:0] c_in;
    logic [7:0] xa_in, ya_in, xb_in, yb_in;

    assign gcol = mfde_pkg::glyph_col(code_reg, gc_reg);

    // Select pixel and whether it is drawn
    always_comb
    begin
        px = x_reg; py = y_reg; pact = 1'b1; pon = 1'b1;
        case (cmd_reg)
            mfde_pkg::CMD_PUT:  pon = color_reg;
            mfde_pkg::CMD_FILL: pon = color_reg;
            mfde_pkg::CMD_FRAME:
            begin
                case (ph_reg)
                    2'd0: py = ya_reg;
                    2'd1: py = yb_reg;
                    2'd2: px = xa_reg;
                    default: px = xb_reg;
                endcase
            end
            mfde_pkg::CMD_CHAR:
            begin
                px   = xa_reg + {5'd0, gc_reg};
                py   = ya_reg + y_reg;
                pact = gcol[y_reg[2:0]];
            end
            default: ;
        endcase
    end

    assign yin   = (py < 8'(mfde_pkg::ROWS));
    assign paddr = {py[mfde_pkg::ROW_W-1:0], px[7:3]};
    assign bitm  = 8'(1) << px[2:0];

    // Step the walk; last flags the final pixel
    always_comb
    begin
        x_next = x_reg; y_next = y_reg; ph_next = ph_reg; gc_next = gc_reg; last = 1'b0;
        case (cmd_reg)
            mfde_pkg::CMD_FILL:
                if (x_reg + 8'd1 < xb_reg) x_next = x_reg + 8'd1;
                else if (y_reg + 8'd1 < yb_reg && y_reg + 8'd1 < 8'(mfde_pkg::ROWS))
                begin
                    x_next = xa_reg; y_next = y_reg + 8'd1;
                end
                else last = 1'b1;
            mfde_pkg::CMD_HLINE:
                if (x_reg + 8'd1 < xb_reg) x_next = x_reg + 8'd1; else last = 1'b1;
            mfde_pkg::CMD_VLINE:
                if (y_reg + 8'd1 < yb_reg && y_reg + 8'd1 < 8'(mfde_pkg::ROWS))
                    y_next = y_reg + 8'd1;
                else last = 1'b1;
            mfde_pkg::CMD_FRAME:
            begin
                case (ph_reg)
                    2'd0: ph_next = 2'd1;
                    2'd1:
                        if (x_reg + 8'd1 < xb_reg)
                        begin
                            x_next = x_reg + 8'd1; ph_next = 2'd0;
                        end
                        else if (ya_reg <= yb_reg && ya_reg < 8'(mfde_pkg::ROWS))
                        begin
                            ph_next = 2'd2; y_next = ya_reg;
                        end
                        else last = 1'b1;
                    2'd2: ph_next = 2'd3;
                    default:
                        if (y_reg < yb_reg && y_reg + 8'd1 < 8'(mfde_pkg::ROWS))
                        begin
                            y_next = y_reg + 8'd1; ph_next = 2'd2;
                        end
                        else last = 1'b1;
                endcase
            end
            mfde_pkg::CMD_CHAR:
                if (y_reg != 8'd7) y_next = y_reg + 8'd1;
                else if (gc_reg + 3'd1 < gw_reg)
                begin
                    y_next = 8'd0; gc_next = gc_reg + 3'd1;
                end
                else last = 1'b1;
            default: last = 1'b1;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        we = 1'b0;
        waddr = paddr;
        wdata = pon ? (rd_reg | bitm) : (rd_reg & ~bitm);
        case (state_reg)
            mfde_pkg::ST_CLEAR:
            begin
                we = 1'b1; waddr = clr_reg; wdata = 8'd0;
                if (clr_reg == mfde_pkg::LAST_ADDR)
                    state_next = mfde_pkg::ST_IDLE;
            end
            mfde_pkg::ST_IDLE:
                if (s_axis_tvalid) state_next = mfde_pkg::ST_NEXT;
            mfde_pkg::ST_NEXT:
                state_next = mfde_pkg::ST_READ;
            mfde_pkg::ST_READ:
                state_next = mfde_pkg::ST_MOD;
            mfde_pkg::ST_MOD:
            begin
                if (cmd_reg != mfde_pkg::CMD_RDPX && cmd_reg != mfde_pkg::CMD_RDBY)
                    we = pact && yin && !(state_reg == mfde_pkg::ST_MOD && empty_reg);
                state_next = last || empty_reg ? mfde_pkg::ST_OUT : mfde_pkg::ST_READ;
            end
            mfde_pkg::ST_OUT:
                if (m_axis_tready) state_next = mfde_pkg::ST_IDLE;
            default: state_next = mfde_pkg::ST_IDLE;
        endcase
    end

    // Split the incoming command word
    assign c_in  = s_axis_tdata[2:0];
    assign xa_in = s_axis_tdata[10:3];
    assign ya_in = s_axis_tdata[18:11];
    assign xb_in = s_axis_tdata[26:19];
    assign yb_in = s_axis_tdata[34:27];

    assign s_axis_tready = (state_reg == mfde_pkg::ST_IDLE);
    assign m_axis_tvalid = (state_reg == mfde_pkg::ST_OUT);
    assign m_axis_tdata  = {4'd0, gw_reg, byte_reg, pix_reg};

    // Frame store: synchronous read, one write port
    always_ff @(posedge clk)
    begin
        if (we) mem[waddr] <= wdata;
        rd_reg <= mem[paddr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mfde_pkg::ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == mfde_pkg::ST_CLEAR) clr_reg <= clr_reg + 1'b1;
        end
    end

    // Command capture, walk and result
    always_ff @(posedge clk)
    begin
        if (state_reg == mfde_pkg::ST_IDLE && s_axis_tvalid)
        begin
            cmd_reg   <= c_in;
            xa_reg    <= xa_in; ya_reg <= ya_in; xb_reg <= xb_in; yb_reg <= yb_in;
            color_reg <= s_axis_tdata[35];
            code_reg  <= s_axis_tdata[43:36];
            x_reg     <= xa_in;
            y_reg     <= (c_in == mfde_pkg::CMD_CHAR) ? 8'd0 : ya_in;
            // A frame with no top and bottom span starts on its sides
            ph_reg    <= (c_in == mfde_pkg::CMD_FRAME && !(xa_in < xb_in)) ? 2'd2 : 2'd0;
            gc_reg    <= 3'd0;
            gw_reg    <= (c_in == mfde_pkg::CMD_CHAR) ?
                         mfde_pkg::glyph_width(s_axis_tdata[43:36]) : 3'd0;
            pix_reg   <= 1'b0;
            byte_reg  <= 8'd0;
            case (c_in)
                mfde_pkg::CMD_FILL:
                    empty_reg <= !(xa_in < xb_in && ya_in < yb_in
                                   && ya_in < 8'(mfde_pkg::ROWS));
                mfde_pkg::CMD_HLINE: empty_reg <= !(xa_in < xb_in);
                mfde_pkg::CMD_VLINE:
                    empty_reg <= !(ya_in < yb_in && ya_in < 8'(mfde_pkg::ROWS));
                mfde_pkg::CMD_FRAME:
                    if (xa_in < xb_in) empty_reg <= 1'b0;
                    else empty_reg <= !(ya_in <= yb_in && ya_in < 8'(mfde_pkg::ROWS));
                default: empty_reg <= 1'b0;
            endcase
        end
        else if (state_reg == mfde_pkg::ST_MOD)
        begin
            x_reg <= x_next; y_reg <= y_next; ph_reg <= ph_next; gc_reg <= gc_next;
            if (cmd_reg == mfde_pkg::CMD_RDPX) pix_reg <= yin & rd_reg[px[2:0]];
            if (cmd_reg == mfde_pkg::CMD_RDBY) byte_reg <= yin ? rd_reg : 8'd0;
        end
    end

endmodule

/* rtl/core/mfde_checker.sv */
// Port-level checks for the framebuffer draw engine.
// Bound to mono_framebuffer_draw_engine; no package use.
module mfde_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    // Never take a command while a result is pending
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready with result pending");
    // Result held until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    // Accepted command is busy next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("double accept");
    // Padding bits are zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:12] == 4'd0) else $error("pad bits set");
endmodule

bind mono_framebuffer_draw_engine mfde_checker u_mfde_checker (.*);
